// ===== src/hfsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hfsc_pkg;

    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 64;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);

    localparam int IN_W  = 16;
    localparam int OUT_W = 32;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // action codes
    localparam logic [2:0] ACT_PUT     = 3'd0;
    localparam logic [2:0] ACT_DRE     = 3'd1;
    localparam logic [2:0] ACT_TXC     = 3'd2;
    localparam logic [2:0] ACT_RECV    = 3'd3;
    localparam logic [2:0] ACT_RX_POP  = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TX_FULL = 2'd1;
    localparam logic [1:0] STAT_RX_EMPT = 2'd2;

    // signal codes
    localparam logic [2:0] SC_NONE   = 3'd0;
    localparam logic [2:0] SC_KILL   = 3'd1;
    localparam logic [2:0] SC_TERM   = 3'd2;
    localparam logic [2:0] SC_PAUSE  = 3'd3;
    localparam logic [2:0] SC_RESUME = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_CRLF   = 3'd0;
    localparam logic [2:0] REG_KILL   = 3'd1;
    localparam logic [2:0] REG_TERM   = 3'd2;
    localparam logic [2:0] REG_PAUSE  = 3'd3;
    localparam logic [2:0] REG_RESUME = 3'd4;

    typedef struct packed {
        logic       crlf_enable;
        logic [7:0] kill_char;
        logic [7:0] terminate_char;
        logic [7:0] pause_char;
        logic [7:0] resume_char;
    } cfg_t;

    typedef struct packed {
        logic             we;
        logic [TX_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [TX_AW-1:0] raddr;
    } tx_mem_req_t;

    typedef struct packed {
        logic             we;
        logic [RX_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [RX_AW-1:0] raddr;
    } rx_mem_req_t;

    // step a ring position downward, wrapping from slot 1 to slot depth-1
    function automatic logic [TX_AW-1:0] tx_down(input logic [TX_AW-1:0] pos);
        logic [TX_AW-1:0] res;
        if (pos <= TX_AW'(1))
            res = TX_AW'(TX_DEPTH - 1);
        else
            res = pos - TX_AW'(1);
        return res;
    endfunction

    function automatic logic [RX_AW-1:0] rx_down(input logic [RX_AW-1:0] pos);
        logic [RX_AW-1:0] res;
        if (pos <= RX_AW'(1))
            res = RX_AW'(RX_DEPTH - 1);
        else
            res = pos - RX_AW'(1);
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/hfsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfsc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/hfsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfsc_ctrl
    import hfsc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [2:0]       in_action,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_tx_ready,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic [OUT_W-1:0] out_data,
    output      tx_mem_req_t      tx_req,
    input  wire logic [7:0]       tx_rdata,
    output      rx_mem_req_t      rx_req,
    input  wire logic [7:0]       rx_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WCR  = 4'b0010,
        ST_READ = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic             mode_reg, mode_next, irq_reg, irq_next;

    // result of the item in flight
    logic [1:0] status_reg, status_next;
    logic       txv_reg, txv_next;
    logic       rxv_reg, rxv_next;
    logic [2:0] sig_reg, sig_next;
    logic       drop_reg, drop_next;
    logic       cr_pend;

    logic             ovalid_reg;
    logic [OUT_W-1:0] odata_reg;
    logic             out_free;

    logic             accept;
    logic [TX_AW-1:0] nh1, nh2, ntt;
    logic [RX_AW-1:0] rnh, rnt;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_free  = !ovalid_reg || out_ready;

    assign nh1 = tx_down(tx_head_reg);
    assign nh2 = tx_down(nh1);
    assign ntt = tx_down(tx_tail_reg);
    assign rnh = rx_down(rx_head_reg);
    assign rnt = rx_down(rx_tail_reg);

    always_comb
    begin
        state_next   = state_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        mode_next    = mode_reg;
        irq_next     = irq_reg;
        status_next  = status_reg;
        txv_next     = txv_reg;
        rxv_next     = rxv_reg;
        sig_next     = sig_reg;
        drop_next    = drop_reg;
        cr_pend      = 1'b0;

        tx_req       = '0;
        tx_req.wdata = in_byte;
        tx_req.waddr = nh1;
        tx_req.raddr = tx_tail_reg;
        rx_req       = '0;
        rx_req.wdata = in_byte;
        rx_req.waddr = rnh;
        rx_req.raddr = rx_tail_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    txv_next    = 1'b0;
                    rxv_next    = 1'b0;
                    sig_next    = SC_NONE;
                    drop_next   = 1'b0;
                    case (in_action)
                        ACT_PUT:
                        begin
                            if (nh1 == tx_tail_reg)
                            begin
                                status_next = STAT_TX_FULL;
                            end
                            else
                            begin
                                tx_req.we    = 1'b1;
                                tx_head_next = nh1;
                                mode_next    = 1'b1;
                                irq_next     = 1'b1;
                                if (cfg.crlf_enable && in_byte == CH_LF
                                    && nh2 == tx_tail_reg)
                                begin
                                    // LF stays queued, CR does not fit
                                    status_next = STAT_TX_FULL;
                                end
                                else
                                begin
                                    if (cfg.crlf_enable && in_byte == CH_LF)
                                    begin
                                        cr_pend      = 1'b1;
                                        tx_head_next = nh2;
                                    end
                                    // ring is non-empty here
                                    if (in_tx_ready)
                                    begin
                                        tx_tail_next = ntt;
                                        txv_next     = 1'b1;
                                    end
                                end
                            end
                        end
                        ACT_DRE:
                        begin
                            if (tx_head_reg != tx_tail_reg)
                            begin
                                tx_tail_next = ntt;
                                txv_next     = 1'b1;
                            end
                            else
                            begin
                                irq_next = 1'b0;
                            end
                        end
                        ACT_TXC:
                        begin
                            mode_next = 1'b0;
                            irq_next  = 1'b0;
                        end
                        ACT_RECV:
                        begin
                            if (in_byte == cfg.kill_char)
                                sig_next = SC_KILL;
                            else if (in_byte == cfg.terminate_char)
                                sig_next = SC_TERM;
                            else if (in_byte == cfg.pause_char)
                                sig_next = SC_PAUSE;
                            else if (in_byte == cfg.resume_char)
                                sig_next = SC_RESUME;
                            else if (rnh != rx_tail_reg)
                            begin
                                rx_req.we    = 1'b1;
                                rx_head_next = rnh;
                            end
                            else
                                drop_next = 1'b1;
                        end
                        ACT_RX_POP:
                        begin
                            if (rx_head_reg == rx_tail_reg)
                                status_next = STAT_RX_EMPT;
                            else
                            begin
                                rx_tail_next = rnt;
                                rxv_next     = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cr_pend)
                        state_next = ST_WCR;
                    else if (txv_next || rxv_next)
                        state_next = ST_READ;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_WCR:
            begin
                // head already points at the CR slot
                tx_req.we    = 1'b1;
                tx_req.waddr = tx_head_reg;
                tx_req.wdata = CH_CR;
                state_next   = txv_reg ? ST_READ : ST_FIN;
            end
            ST_READ:
            begin
                // tail already points at the slot to read
                tx_req.re  = txv_reg;
                rx_req.re  = rxv_reg;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tx_head_reg <= TX_AW'(1);
            tx_tail_reg <= TX_AW'(1);
            rx_head_reg <= RX_AW'(1);
            rx_tail_reg <= RX_AW'(1);
            mode_reg    <= 1'b0;
            irq_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            mode_reg    <= mode_next;
            irq_reg     <= irq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        txv_reg    <= txv_next;
        rxv_reg    <= rxv_next;
        sig_reg    <= sig_next;
        drop_reg   <= drop_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (state_reg == ST_FIN && out_free)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            odata_reg <= {6'b0,
                          rxv_reg ? rx_rdata : 8'h00,
                          rxv_reg, drop_reg, sig_reg, irq_reg, mode_reg,
                          txv_reg ? tx_rdata : 8'h00,
                          txv_reg, status_reg};
        end
    end

endmodule
`default_nettype wire

// ===== src/half_duplex_serial_fifo_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Half-duplex serial FIFO controller: transmit ring and receive ring with
// line direction and transmit interrupt tracking.
// Input stream (s_axis): one beat per event - put byte, data register
// empty, transmit complete, byte received, receive pop.
// Output stream (m_axis): exactly one result beat per input beat, in order.
// Config port: cfg_wr_en/cfg_index/cfg_wdata, write only, while idle.
// Sequence: after the input beat the sequencer goes through the CR write
// state for an LF put under CR/LF, the ring read state for events that
// send or pop a byte, then the finish state that loads the output register.
// The sequencer takes the next input beat only once it is back in idle; it
// walks the one write port and the one read port of each ring RAM (CR
// write, then read of the new tail slot, registered read data).
// The input is taken again as soon as the sequencer is back in idle, even
// while the previous result beat is still waiting in the output register.
// If the receiver stalls, at most one further beat completes and holds in
// the sequencer until the output register frees up.
// Reset: all ring pointers go to slot 1 (both rings empty), receive
// direction, transmit interrupt off, config to defaults. Ring RAMs are not
// cleared and need no clearing pass.
module half_duplex_serial_fifo_controller
    import hfsc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output      logic             s_axis_tready,
    // [2:0] action, [10:3] data_byte, [11] tx_reg_ready, [15:12] zero
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output      logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [1:0] status, [2] tx_valid, [10:3] tx_byte, [11] drive_enable,
    // [12] tx_irq_enable, [15:13] signal_code, [16] rx_dropped,
    // [17] rx_valid, [25:18] rx_byte, [31:26] zero
    output      logic [OUT_W-1:0] m_axis_tdata,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [7:0]       cfg_wdata
);

    cfg_t        cfg_reg;
    tx_mem_req_t tx_req;
    rx_mem_req_t rx_req;
    logic [7:0]  tx_rdata, rx_rdata;

    // config registers; writes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crlf_enable    <= 1'b0;
            cfg_reg.kill_char      <= 8'd3;
            cfg_reg.terminate_char <= 8'd4;
            cfg_reg.pause_char     <= 8'd19;
            cfg_reg.resume_char    <= 8'd17;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CRLF:   cfg_reg.crlf_enable    <= cfg_wdata[0];
                REG_KILL:   cfg_reg.kill_char      <= cfg_wdata;
                REG_TERM:   cfg_reg.terminate_char <= cfg_wdata;
                REG_PAUSE:  cfg_reg.pause_char     <= cfg_wdata;
                REG_RESUME: cfg_reg.resume_char    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer, ring pointers and output register
    hfsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tdata[2:0]),
        .in_byte     (s_axis_tdata[10:3]),
        .in_tx_ready (s_axis_tdata[11]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .tx_req      (tx_req),
        .tx_rdata    (tx_rdata),
        .rx_req      (rx_req),
        .rx_rdata    (rx_rdata)
    );

    // transmit ring storage
    hfsc_ram #(
        .DEPTH (TX_DEPTH),
        .WIDTH (8)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_req.we),
        .waddr (tx_req.waddr),
        .wdata (tx_req.wdata),
        .re    (tx_req.re),
        .raddr (tx_req.raddr),
        .rdata (tx_rdata)
    );

    // receive ring storage
    hfsc_ram #(
        .DEPTH (RX_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_req.we),
        .waddr (rx_req.waddr),
        .wdata (rx_req.wdata),
        .re    (rx_req.re),
        .raddr (rx_req.raddr),
        .rdata (rx_rdata)
    );

endmodule
`default_nettype wire
